/* src/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, result status codes and control types for the bitmap
// block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_BLOCKS  = 256;
    localparam int DEF_MAX_REQUEST = 16;

    // The free map is stored as rows of WORD_W bits, one bit per block.
    localparam int WORD_W = 16;
    localparam int BIT_W  = 4;

    // Field widths.
    localparam int CFG_W   = 9;
    localparam int COUNT_W = 5;
    localparam int INDEX_W = 8;
    localparam int STAT_W  = 3;
    localparam int FREE_W  = 9;

    // Block total after reset.
    localparam int TOTAL_RESET = 256;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_GRANTED  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_INSUFF   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_RELEASED = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] STAT_BADIDX   = 3'd4;

    // Control from the top level to the request sequencer.
    typedef struct packed {
        logic busy;   // free map clearing pass in progress
        logic load;   // block total written, reload the free count
    } sweep_ctl_t;

endpackage

/* src/bba_map_ram.sv */
// ----------------------------------------------------------------------------
// bba_map_ram
// Free map storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bba_map_ram #(
    parameter int ROWS  = 16,
    parameter int ROW_W = 4
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [ROW_W-1:0]           wr_addr,
    input  logic [bba_pkg::WORD_W-1:0] wr_data,
    input  logic [ROW_W-1:0]           rd_addr,
    output logic [bba_pkg::WORD_W-1:0] rd_data
);
    import bba_pkg::*;

    logic [WORD_W-1:0] mem [ROWS];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/bba_ctrl.sv */
// ----------------------------------------------------------------------------
// bba_ctrl
// Request sequencer: reads, modifies and writes back free map rows, scans
// rows for free blocks and drives the result register.
// ----------------------------------------------------------------------------
module bba_ctrl #(
    parameter int MAX_BLOCKS  = 256,
    parameter int MAX_REQUEST = 16,
    parameter int ROW_W       = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bba_pkg::sweep_ctl_t         sweep,
    input  logic [bba_pkg::CFG_W-1:0]   eff_total,
    input  logic [bba_pkg::FREE_W-1:0]  load_total,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_req_type,
    input  logic [bba_pkg::COUNT_W-1:0] s_block_count,
    input  logic [bba_pkg::INDEX_W-1:0] s_release_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bba_pkg::INDEX_W-1:0] m_granted_index,
    output logic [bba_pkg::STAT_W-1:0]  m_status,
    output logic                        m_last,
    output logic [bba_pkg::FREE_W-1:0]  m_free_count_out,
    output logic                        wr_en,
    output logic [ROW_W-1:0]            wr_addr,
    output logic [bba_pkg::WORD_W-1:0]  wr_data,
    output logic [ROW_W-1:0]            rd_addr,
    input  logic [bba_pkg::WORD_W-1:0]  rd_data
);
    import bba_pkg::*;

    localparam int BI_W     = ROW_W + BIT_W;
    localparam int CMP_W    = (BI_W > CFG_W) ? BI_W : CFG_W;
    localparam int CAP      = (MAX_BLOCKS < 511) ? MAX_BLOCKS : 511;
    localparam int RST_FREE = (TOTAL_RESET < CAP) ? TOTAL_RESET : CAP;
    localparam int REQ_W    = 7;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_REL_MOD = 3'd1;
    localparam logic [2:0] S_A_LOAD  = 3'd2;
    localparam logic [2:0] S_A_SCAN  = 3'd3;
    localparam logic [2:0] S_A_WB    = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic [WORD_W-1:0]  mask_reg, mask_next;
    logic [FREE_W-1:0]  free_reg, free_next;

    logic               m_valid_reg;
    logic [INDEX_W-1:0] m_index_reg;
    logic [STAT_W-1:0]  m_status_reg;
    logic               m_last_reg;
    logic [FREE_W-1:0]  m_free_reg;

    logic               emit;
    logic [INDEX_W-1:0] e_index;
    logic [STAT_W-1:0]  e_status;
    logic               e_last;
    logic [FREE_W-1:0]  e_free;

    logic               out_free;
    logic [BI_W-1:0]    rel_ext;
    logic               rel_bad;
    logic               too_many;
    logic [WORD_W-1:0]  avail;
    logic [BIT_W-1:0]   pos;
    logic [WORD_W-1:0]  row_mask;

    assign out_free = !m_valid_reg || m_ready;
    assign rel_ext  = BI_W'(s_release_index);
    assign rel_bad  = CMP_W'(s_release_index) >= CMP_W'(eff_total);
    assign too_many = (REQ_W'(s_block_count) > REQ_W'(MAX_REQUEST))
                   || (FREE_W'(s_block_count) > free_reg);
    assign avail    = word_reg & mask_reg;

    // Lowest free block in the working row.
    always_comb begin
        pos = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (avail[j]) begin
                pos = BIT_W'(j);
            end
        end
    end

    // Blocks at or above the total are never handed out.
    always_comb begin
        for (int j = 0; j < WORD_W; j++) begin
            row_mask[j] = CMP_W'({row_reg, BIT_W'(j)}) < CMP_W'(eff_total);
        end
    end

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        word_next  = word_reg;
        mask_next  = mask_reg;
        free_next  = free_reg;
        rd_addr    = row_reg;
        wr_en      = 1'b0;
        wr_addr    = row_reg;
        wr_data    = word_reg;
        s_ready    = 1'b0;
        emit       = 1'b0;
        e_index    = '0;
        e_status   = STAT_GRANTED;
        e_last     = 1'b1;
        e_free     = free_reg;

        case (state_reg)
            S_IDLE: begin
                s_ready = !sweep.busy && out_free;
                if (s_valid && s_ready) begin
                    if (s_req_type) begin
                        if (rel_bad) begin
                            emit     = 1'b1;
                            e_status = STAT_BADIDX;
                        end else begin
                            row_next   = rel_ext[BI_W-1:BIT_W];
                            bit_next   = rel_ext[BIT_W-1:0];
                            rd_addr    = rel_ext[BI_W-1:BIT_W];
                            state_next = S_REL_MOD;
                        end
                    end else if (s_block_count == '0) begin
                        emit     = 1'b1;
                        e_status = STAT_EMPTY;
                    end else if (too_many) begin
                        emit     = 1'b1;
                        e_status = STAT_INSUFF;
                    end else begin
                        rem_next   = s_block_count;
                        row_next   = '0;
                        rd_addr    = '0;
                        state_next = S_A_LOAD;
                    end
                end
            end
            S_REL_MOD: begin
                if (out_free) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data | (WORD_W'(1) << bit_reg);
                    if (!rd_data[bit_reg]) begin
                        free_next = free_reg + 1'b1;
                    end
                    emit       = 1'b1;
                    e_status   = STAT_RELEASED;
                    e_free     = free_next;
                    state_next = S_IDLE;
                end
            end
            S_A_LOAD: begin
                word_next  = rd_data;
                mask_next  = row_mask;
                state_next = S_A_SCAN;
            end
            S_A_SCAN: begin
                if (avail == '0) begin
                    state_next = S_A_WB;
                end else if (out_free) begin
                    free_next = free_reg - 1'b1;
                    emit      = 1'b1;
                    e_index   = INDEX_W'({row_reg, pos});
                    e_status  = STAT_GRANTED;
                    e_last    = (rem_reg == COUNT_W'(1));
                    e_free    = free_next;
                    word_next = word_reg & ~(WORD_W'(1) << pos);
                    rem_next  = rem_reg - 1'b1;
                    if (rem_reg == COUNT_W'(1)) begin
                        state_next = S_A_WB;
                    end
                end
            end
            S_A_WB: begin
                wr_en = 1'b1;
                if (rem_reg == '0) begin
                    state_next = S_IDLE;
                end else begin
                    row_next   = row_reg + 1'b1;
                    rd_addr    = row_reg + 1'b1;
                    state_next = S_A_LOAD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (sweep.load) begin
            free_next = load_total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            free_reg    <= FREE_W'(RST_FREE);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            free_reg  <= free_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        row_reg  <= row_next;
        bit_reg  <= bit_next;
        rem_reg  <= rem_next;
        word_reg <= word_next;
        mask_reg <= mask_next;
        if (emit) begin
            m_index_reg  <= e_index;
            m_status_reg <= e_status;
            m_last_reg   <= e_last;
            m_free_reg   <= e_free;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_granted_index  = m_index_reg;
    assign m_status         = m_status_reg;
    assign m_last           = m_last_reg;
    assign m_free_count_out = m_free_reg;

endmodule

/* src/bitmap_block_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a free map held in a row-organized memory.
// ----------------------------------------------------------------------------
// Usage: the request channel (s_*) carries one allocate or release per
// transfer. An allocate for N blocks produces N result transfers on m_*,
// one granted block each in ascending order, the last one marked by m_last.
// An allocate that cannot be served, a zero-length allocate, a release and
// a release with a bad index each produce a single result transfer.
// Sequencing: rejected requests (bad index, zero-length, insufficient)
// appear on m_* the cycle after acceptance. A release reads the row, then
// writes it back with the block marked free. An allocate reads each row of
// 16 blocks it visits, grants one block per cycle from that row while the
// result register is free or being emptied, then writes the row back.
// The next request is taken once the current one has finished and the
// result register is free or being emptied.
// Reset and configuration: after reset, and after every write of the block
// total, a clearing pass marks every row free, starting from row zero, and
// s_ready stays low meanwhile.
// Stalls: when m_ready is low the result waits in the output register and
// the scan holds until it is taken.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS  = bba_pkg::DEF_MAX_BLOCKS,
    parameter int MAX_REQUEST = bba_pkg::DEF_MAX_REQUEST
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [bba_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_req_type,
    input  logic [bba_pkg::COUNT_W-1:0] s_block_count,
    input  logic [bba_pkg::INDEX_W-1:0] s_release_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bba_pkg::INDEX_W-1:0] m_granted_index,
    output logic [bba_pkg::STAT_W-1:0]  m_status,
    output logic                        m_last,
    output logic [bba_pkg::FREE_W-1:0]  m_free_count_out
);
    import bba_pkg::*;

    // Free map geometry: rows of WORD_W blocks.
    localparam int ROWS  = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    // A total above the number of built blocks acts as that number.
    localparam int CAP   = (MAX_BLOCKS < 511) ? MAX_BLOCKS : 511;
    localparam logic [CFG_W-1:0] CAP_V = CFG_W'(CAP);

    logic [CFG_W-1:0]  total_reg;
    logic [CFG_W-1:0]  eff_total;
    logic [CFG_W-1:0]  load_total;
    logic              clr_active_reg;
    logic [ROW_W-1:0]  clr_row_reg;
    sweep_ctl_t        sweep;

    logic              c_wr_en;
    logic [ROW_W-1:0]  c_wr_addr;
    logic [WORD_W-1:0] c_wr_data;
    logic              ram_wr_en;
    logic [ROW_W-1:0]  ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;
    logic [ROW_W-1:0]  ram_rd_addr;
    logic [WORD_W-1:0] ram_rd_data;

    assign eff_total  = (total_reg > CAP_V) ? CAP_V : total_reg;
    assign load_total = (cfg_wr_data > CAP_V) ? CAP_V : cfg_wr_data;

    // Block total register and the clearing pass that it triggers. The pass
    // writes one row of all-free bits per cycle, starting from row zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg      <= CFG_W'(TOTAL_RESET);
            clr_active_reg <= 1'b1;
            clr_row_reg    <= '0;
        end else if (cfg_wr_en) begin
            total_reg      <= cfg_wr_data;
            clr_active_reg <= 1'b1;
            clr_row_reg    <= '0;
        end else if (clr_active_reg) begin
            if (clr_row_reg == ROW_W'(ROWS - 1)) begin
                clr_active_reg <= 1'b0;
            end else begin
                clr_row_reg <= clr_row_reg + 1'b1;
            end
        end
    end

    assign sweep.busy = clr_active_reg;
    assign sweep.load = cfg_wr_en;

    // The clearing pass owns the write port while it runs; the sequencer takes
    // no new request until the pass has finished.
    assign ram_wr_en   = clr_active_reg || c_wr_en;
    assign ram_wr_addr = clr_active_reg ? clr_row_reg : c_wr_addr;
    assign ram_wr_data = clr_active_reg ? {WORD_W{1'b1}} : c_wr_data;

    bba_map_ram #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    bba_ctrl #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .MAX_REQUEST (MAX_REQUEST),
        .ROW_W       (ROW_W)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .sweep            (sweep),
        .eff_total        (eff_total),
        .load_total       (load_total),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_block_count    (s_block_count),
        .s_release_index  (s_release_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_granted_index  (m_granted_index),
        .m_status         (m_status),
        .m_last           (m_last),
        .m_free_count_out (m_free_count_out),
        .wr_en            (c_wr_en),
        .wr_addr          (c_wr_addr),
        .wr_data          (c_wr_data),
        .rd_addr          (ram_rd_addr),
        .rd_data          (ram_rd_data)
    );

endmodule

/* src/bba_checker.sv */
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks for the bitmap block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [bba_pkg::INDEX_W-1:0] m_granted_index,
    input logic [bba_pkg::STAT_W-1:0]  m_status,
    input logic                        m_last,
    input logic [bba_pkg::FREE_W-1:0]  m_free_count_out
);
    import bba_pkg::*;

    // No result is offered right after a reset cycle.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_granted_index)
            && $stable(m_status) && $stable(m_last) && $stable(m_free_count_out))
        else $error("stalled result changed");

    // Anything but a grant is a single, closing result with no block number.
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_GRANTED |-> m_last && m_granted_index == '0)
        else $error("non-grant result not final or carries an index");

    // While a multi-block grant is still in flight no new request is taken.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_status == STAT_GRANTED && !m_last |=> !s_ready)
        else $error("request taken during an unfinished allocation");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_granted_index  (m_granted_index),
    .m_status         (m_status),
    .m_last           (m_last),
    .m_free_count_out (m_free_count_out)
);
